// ----- hdl/bchenc_pkg.sv -----
package bchenc_pkg;

  // Sizing
  localparam int unsigned ParityMax  = 32;  // cells in the remainder chain
  localparam int unsigned CountWidth = 16;  // message bit counter width
  localparam int unsigned GenW       = 32;  // gen_poly register width
  localparam int unsigned ParLenW    = 6;   // parity_len register width
  localparam int unsigned MsgLenW    = 16;  // msg_len register width
  localparam int unsigned CfgIdxW    = 2;   // config register index width
  localparam int unsigned RemIdxW    = (ParityMax > 1) ? $clog2(ParityMax) : 1;

  // Register reset values
  localparam logic [GenW-1:0]    GenPolyRst   = GenW'(3);
  localparam logic [ParLenW-1:0] ParityLenRst = ParLenW'(3);
  localparam logic [MsgLenW-1:0] MsgLenRst    = MsgLenW'(4);

  // Config register map
  typedef enum logic [CfgIdxW-1:0] {
    RegGenPoly   = 2'd0,
    RegParityLen = 2'd1,
    RegMsgLen    = 2'd2
  } cfg_reg_e;

  // Per-cycle control shared by every cell of the chain
  typedef struct packed {
    logic shift;  // advance the chain this cycle
    logic fb;     // feedback bit (zero while parity drains)
  } cell_ctrl_t;

endpackage

// ----- hdl/bchenc_cell.sv -----
module bchenc_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bchenc_pkg::cell_ctrl_t  ctrl_i,
  input  logic                    active_i,  // cell index below parity length
  input  logic                    gen_i,     // generator coefficient for this cell
  input  logic                    prev_i,    // lower neighbor's bit
  output logic                    bit_o
);

  logic rem_d, rem_q;

  // Shift in the neighbor bit, fold in feedback; inactive cells stay clear
  assign rem_d = active_i & (prev_i ^ (ctrl_i.fb & gen_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      rem_q <= rem_d;
    end
  end

  assign bit_o = rem_q;

endmodule

// ----- hdl/bch_systematic_encoder_core.sv -----
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata[0] msg_bit
// m_axis    out  tdata[0] code_bit, tuser[0] is_parity, tlast block_last
// cfg       in   cfg_index_i register index, cfg_data_i value
//
// One message bit per cycle: it goes straight to the output register and
// shifts the remainder chain once (held while the parity length is zero, until the block ends).
// After a block's last message bit the input stalls while the chain drains
// its remainder of min(parity_len, 32) bits, top bit first.
// Output stalls hold the output register and stretch both phases.
// Reset clears the remainder and counters and loads register defaults.
module bch_systematic_encoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // message input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [0] msg_bit
  // code output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,   // [0] code_bit
  output logic                               m_axis_tuser,   // [0] is_parity
  output logic                               m_axis_tlast,   // block_last
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bchenc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bchenc_pkg::GenW-1:0]        cfg_data_i
);

  localparam int unsigned ParityMax  = bchenc_pkg::ParityMax;
  localparam int unsigned CountWidth = bchenc_pkg::CountWidth;
  localparam int unsigned GenW       = bchenc_pkg::GenW;
  localparam int unsigned ParLenW    = bchenc_pkg::ParLenW;
  localparam int unsigned MsgLenW    = bchenc_pkg::MsgLenW;
  localparam int unsigned RemIdxW    = bchenc_pkg::RemIdxW;

  // Configuration registers
  logic [GenW-1:0]    gen_poly_q;
  logic [ParLenW-1:0] parity_len_q;
  logic [MsgLenW-1:0] msg_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_poly_q   <= bchenc_pkg::GenPolyRst;
      parity_len_q <= bchenc_pkg::ParityLenRst;
      msg_len_q    <= bchenc_pkg::MsgLenRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bchenc_pkg::RegGenPoly:   gen_poly_q   <= cfg_data_i;
        bchenc_pkg::RegParityLen: parity_len_q <= cfg_data_i[ParLenW-1:0];
        bchenc_pkg::RegMsgLen:    msg_len_q    <= cfg_data_i[MsgLenW-1:0];
        default: ;
      endcase
    end
  end

  // Effective parity length, saturated to the chain length
  logic [ParLenW-1:0] r_eff;
  logic [ParLenW-1:0] r_m1;
  assign r_eff = (parity_len_q > ParLenW'(ParityMax)) ? ParLenW'(ParityMax) : parity_len_q;
  assign r_m1  = r_eff - ParLenW'(1);

  // Handshake and flow state
  logic                  out_vld_q, out_vld_d;
  logic                  out_bit_q, out_bit_d;
  logic                  out_par_q, out_par_d;
  logic                  out_last_q, out_last_d;
  logic [ParLenW-1:0]    tail_q, tail_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [CountWidth-1:0] cnt_nxt;
  logic [CountWidth-1:0] len_cmp;
  logic                  out_free, tail_busy, in_xfer, tail_step, blk_end;
  logic                  msg_bit, top_bit;
  logic [ParityMax-1:0]  rem;
  bchenc_pkg::cell_ctrl_t ctrl;

  assign out_free  = !out_vld_q || m_axis_tready;
  assign tail_busy = (tail_q != '0);
  assign s_axis_tready = out_free && !tail_busy;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign tail_step = out_free && tail_busy;
  assign msg_bit   = s_axis_tdata[0];

  // Block length compare within the counter width
  if (CountWidth <= MsgLenW) begin : g_len_trunc
    assign len_cmp = msg_len_q[CountWidth-1:0];
  end else begin : g_len_ext
    assign len_cmp = {{(CountWidth-MsgLenW){1'b0}}, msg_len_q};
  end

  assign cnt_nxt = cnt_q + CountWidth'(1);
  assign blk_end = (cnt_nxt == len_cmp);

  // Top remainder bit: feedback tap and parity output
  assign top_bit = (r_eff != '0) ? rem[r_m1[RemIdxW-1:0]] : 1'b0;

  // With no parity the chain keeps its bits until the block ends
  assign ctrl.shift = tail_step || (in_xfer && ((r_eff != '0) || blk_end));
  assign ctrl.fb    = in_xfer && (msg_bit ^ top_bit);

  // Remainder cell chain
  for (genvar i = 0; i < ParityMax; i++) begin : g_cell
    logic prev, gen_bit, active;
    if (i == 0) begin : g_first
      assign prev    = 1'b0;
      assign gen_bit = 1'b1;
    end else begin : g_rest
      assign prev = rem[i-1];
      if (i < GenW) begin : g_gen
        assign gen_bit = gen_poly_q[i];
      end else begin : g_nogen
        assign gen_bit = 1'b0;
      end
    end
    assign active = (r_eff > ParLenW'(i));

    bchenc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .active_i (active),
      .gen_i    (gen_bit),
      .prev_i   (prev),
      .bit_o    (rem[i])
    );
  end

  // Output register, counter and parity tail next state
  always_comb begin
    out_vld_d  = out_vld_q;
    out_bit_d  = out_bit_q;
    out_par_d  = out_par_q;
    out_last_d = out_last_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    priority if (in_xfer) begin
      out_vld_d  = 1'b1;
      out_bit_d  = msg_bit;
      out_par_d  = 1'b0;
      out_last_d = blk_end && (r_eff == '0);
      tail_d     = blk_end ? r_eff : '0;
      cnt_d      = blk_end ? '0 : cnt_nxt;
    end else if (tail_step) begin
      out_vld_d  = 1'b1;
      out_bit_d  = top_bit;
      out_par_d  = 1'b1;
      out_last_d = (tail_q == ParLenW'(1));
      tail_d     = tail_q - ParLenW'(1);
    end else if (m_axis_tready) begin
      out_vld_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      tail_q    <= '0;
      cnt_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    out_bit_q  <= out_bit_d;
    out_par_q  <= out_par_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_bit_q};
  assign m_axis_tuser  = out_par_q;
  assign m_axis_tlast  = out_last_q;

endmodule
